@@ design/whp_pkg.sv @@
// Shared types, tag constants and a helper for the WAV header parser.
package whp_pkg;

    typedef enum logic [3:0] {
        PH_RIFF_TAG   = 4'd0,
        PH_RIFF_SIZE  = 4'd1,
        PH_WAVE_TAG   = 4'd2,
        PH_FMT_TAG    = 4'd3,
        PH_FMT_SIZE   = 4'd4,
        PH_FORMAT     = 4'd5,
        PH_CHANNELS   = 4'd6,
        PH_RATE       = 4'd7,
        PH_AVG        = 4'd8,
        PH_ALIGN      = 4'd9,
        PH_BITS       = 4'd10,
        PH_SKIP       = 4'd11,
        PH_CHUNK_TAG  = 4'd12,
        PH_CHUNK_SIZE = 4'd13,
        PH_DONE       = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FORMAT  = 2'd1,
        ST_OVERRUN = 2'd2
    } status_t;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN  = 32'h0000_0010;

    typedef struct packed {
        logic       first;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] audio_format;
        logic [15:0] num_channels;
        logic [31:0] sample_rate;
        logic [31:0] avg_byte_rate;
        logic [15:0] block_alignment;
        logic [15:0] sample_bits;
        logic [31:0] pcm_start;
        logic [31:0] pcm_length;
    } result_t;

    // Byte count of the item read in each phase.
    function automatic logic [2:0] item_size(input phase_t ph);
        logic [2:0] size;
        case (ph)
            PH_FORMAT, PH_CHANNELS, PH_ALIGN, PH_BITS: size = 3'd2;
            PH_SKIP, PH_DONE:                          size = 3'd1;
            default:                                   size = 3'd4;
        endcase
        return size;
    endfunction

endpackage

@@ design/whp_in_reg.sv @@
// Input register stage: holds one byte request until the parser takes it.
module whp_in_reg
    import whp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       advance,
    output logic       item_valid,
    output in_item_t   item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.first      <= s_tuser;
            item_reg.byte_value <= s_tdata;
        end
    end

endmodule

@@ design/whp_parse.sv @@
// Parser core: phase tracking, field assembly and length checks, one byte per step.
module whp_parse
    import whp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  in_item_t    item,
    input  logic [31:0] total_len,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [1:0]  idx_reg, idx_next;
    logic [23:0] asm_reg, asm_next;
    logic [31:0] skip_reg, skip_next;
    logic        fact_reg, fact_next;
    logic [15:0] fmt_tag_reg, fmt_tag_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] avg_reg, avg_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] ext_reg, ext_next;
    logic [31:0] tag_reg, tag_next;

    phase_t      eff_phase;
    logic [31:0] eff_pos;
    logic [1:0]  eff_idx;
    logic        eff_fact;
    logic [31:0] pos_inc;
    logic [31:0] rem;
    logic [31:0] rem_inc;
    logic [2:0]  size;
    logic [2:0]  idx_plus;
    logic [31:0] word;
    logic [31:0] skip_cnt;

    // A first-byte mark restarts the parse before this byte is used.
    assign eff_phase = item.first ? PH_RIFF_TAG : phase_reg;
    assign eff_pos   = item.first ? 32'd0 : pos_reg;
    assign eff_idx   = item.first ? 2'd0 : idx_reg;
    assign eff_fact  = item.first ? 1'b0 : fact_reg;

    assign pos_inc  = eff_pos + 32'd1;
    assign rem      = (eff_pos <= total_len) ? total_len - eff_pos : 32'd0;
    assign rem_inc  = (pos_inc <= total_len) ? total_len - pos_inc : 32'd0;
    assign size     = item_size(eff_phase);
    assign idx_plus = {1'b0, eff_idx} + 3'd1;
    assign skip_cnt = (eff_phase == PH_BITS) ? ext_reg : word;

    always_comb begin
        case (eff_idx)
            2'd0:    word = {24'd0, item.byte_value};
            2'd1:    word = {16'd0, item.byte_value, asm_reg[7:0]};
            2'd2:    word = {8'd0, item.byte_value, asm_reg[15:0]};
            default: word = {item.byte_value, asm_reg};
        endcase
    end

    always_comb begin
        phase_next   = eff_phase;
        pos_next     = eff_pos;
        idx_next     = eff_idx;
        asm_next     = asm_reg;
        skip_next    = skip_reg;
        fact_next    = eff_fact;
        fmt_tag_next = fmt_tag_reg;
        chan_next    = chan_reg;
        rate_next    = rate_reg;
        avg_next     = avg_reg;
        align_next   = align_reg;
        bits_next    = bits_reg;
        ext_next     = ext_reg;
        tag_next     = tag_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (eff_phase == PH_DONE) begin
            // drop bytes until the next mark
        end else if (eff_phase == PH_SKIP) begin
            pos_next = pos_inc;
            if (skip_reg <= 32'd1) begin
                skip_next  = 32'd0;
                phase_next = PH_CHUNK_TAG;
            end else begin
                skip_next = skip_reg - 32'd1;
            end
        end else if (eff_idx == 2'd0 && rem < {29'd0, size}) begin
            res_valid  = 1'b1;
            res.status = ST_OVERRUN;
            phase_next = PH_DONE;
        end else begin
            pos_next = pos_inc;
            asm_next = word[23:0];
            if (idx_plus < size) begin
                idx_next = idx_plus[1:0];
            end else begin
                idx_next = 2'd0;
                case (eff_phase)
                    PH_RIFF_TAG: begin
                        if (word != TAG_RIFF) begin
                            res_valid  = 1'b1;
                            res.status = ST_FORMAT;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_RIFF_SIZE;
                        end
                    end
                    PH_RIFF_SIZE: phase_next = PH_WAVE_TAG;
                    PH_WAVE_TAG: begin
                        if (word != TAG_WAVE) begin
                            res_valid  = 1'b1;
                            res.status = ST_FORMAT;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_FMT_TAG;
                        end
                    end
                    PH_FMT_TAG: begin
                        if (word != TAG_FMT) begin
                            res_valid  = 1'b1;
                            res.status = ST_FORMAT;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_FMT_SIZE;
                        end
                    end
                    PH_FMT_SIZE: begin
                        if (word < FMT_MIN) begin
                            res_valid  = 1'b1;
                            res.status = ST_FORMAT;
                            phase_next = PH_DONE;
                        end else begin
                            // keep only the extension length for the later skip
                            ext_next   = word - FMT_MIN;
                            phase_next = PH_FORMAT;
                        end
                    end
                    PH_FORMAT: begin
                        fmt_tag_next = word[15:0];
                        phase_next   = PH_CHANNELS;
                    end
                    PH_CHANNELS: begin
                        chan_next  = word[15:0];
                        phase_next = PH_RATE;
                    end
                    PH_RATE: begin
                        rate_next  = word;
                        phase_next = PH_AVG;
                    end
                    PH_AVG: begin
                        avg_next   = word;
                        phase_next = PH_ALIGN;
                    end
                    PH_ALIGN: begin
                        align_next = word[15:0];
                        phase_next = PH_BITS;
                    end
                    PH_CHUNK_TAG: begin
                        tag_next   = word;
                        phase_next = PH_CHUNK_SIZE;
                    end
                    PH_BITS, PH_CHUNK_SIZE: begin
                        if (eff_phase == PH_BITS) begin
                            bits_next = word[15:0];
                        end
                        if (eff_phase == PH_BITS || (!eff_fact && tag_reg == TAG_FACT)) begin
                            // start a skip over the fmt extension or the fact body
                            if (eff_phase == PH_CHUNK_SIZE) begin
                                fact_next = 1'b1;
                            end
                            if (skip_cnt > rem_inc) begin
                                res_valid  = 1'b1;
                                res.status = ST_OVERRUN;
                                phase_next = PH_DONE;
                            end else if (skip_cnt == 32'd0) begin
                                phase_next = PH_CHUNK_TAG;
                            end else begin
                                skip_next  = skip_cnt;
                                phase_next = PH_SKIP;
                            end
                        end else if (tag_reg != TAG_DATA) begin
                            res_valid  = 1'b1;
                            res.status = ST_FORMAT;
                            phase_next = PH_DONE;
                        end else if (word > rem_inc) begin
                            res_valid  = 1'b1;
                            res.status = ST_OVERRUN;
                            phase_next = PH_DONE;
                        end else begin
                            res_valid           = 1'b1;
                            res.status          = ST_OK;
                            res.audio_format    = fmt_tag_reg;
                            res.num_channels    = chan_reg;
                            res.sample_rate     = rate_reg;
                            res.avg_byte_rate   = avg_reg;
                            res.block_alignment = align_reg;
                            res.sample_bits     = bits_reg;
                            res.pcm_start       = pos_inc;
                            res.pcm_length      = word;
                            phase_next          = PH_DONE;
                        end
                    end
                    default: phase_next = eff_phase;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RIFF_TAG;
            pos_reg   <= 32'd0;
            idx_reg   <= 2'd0;
            skip_reg  <= 32'd0;
            fact_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            skip_reg  <= skip_next;
            fact_reg  <= fact_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            asm_reg     <= asm_next;
            fmt_tag_reg <= fmt_tag_next;
            chan_reg    <= chan_next;
            rate_reg    <= rate_next;
            avg_reg     <= avg_next;
            align_reg   <= align_next;
            bits_reg    <= bits_next;
            ext_reg     <= ext_next;
            tag_reg     <= tag_next;
        end
    end

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status != ST_OK) |-> (res.pcm_start == 32'd0 && res.pcm_length == 32'd0))
        else $error("failure result carries nonzero payload");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE && !(step && item.first)) |=> phase_reg == PH_DONE)
        else $error("parser left the done phase without a first-byte mark");

    a_idx_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd0 |-> (phase_reg != PH_SKIP && phase_reg != PH_DONE))
        else $error("field byte index set outside a field read");

endmodule

@@ design/whp_out_reg.sv @@
// Result register: holds one parse result until the downstream side takes it.
module whp_out_reg
    import whp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res_in,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

@@ design/wav_header_parser.sv @@
// Top level of the WAV header parser: input register, parser core, result register.
//
// The parser takes a WAV file one byte per request on the s_ stream (s_tuser high marks
// the first byte of a file and restarts the parse), checks the RIFF, WAVE and fmt tags
// and a fmt size of at least 16, reads the six format fields, skips an optional fact
// chunk and checks the data tag. It sends exactly one result on the m_ stream once the
// data chunk size is read or a check fails: status in m_tuser (0 ok, 1 bad tag or short
// fmt, 2 read, skip or PCM size past the file length) and the format fields, PCM offset
// and PCM length in m_tdata, all zero on failure. Bytes after the result are dropped
// until the next first-byte mark. Program the file length through cfg_we/cfg_wdata while
// no file is in flight. Throughput is one byte per clock unless a result waits on
// m_tready: each request passes the input register, the combinational parser logic (a
// 32-bit remaining-length subtract and compare sets that path) and, for the byte ending
// the header, the result register, so m_tvalid rises on the edge that steps the parser
// on that byte. A result stalled on m_tready holds the input register and s_tready.
module wav_header_parser
    import whp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: file length in bytes
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    // byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_value
    input  logic         s_tuser,   // [0] first_byte
    // parse result out
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] audio_format, [31:16] num_channels, [63:32] sample_rate,
    // [95:64] avg_byte_rate, [111:96] block_alignment, [127:112] sample_bits,
    // [159:128] pcm_start, [191:160] pcm_length
    output logic [191:0] m_tdata,
    output logic [1:0]   m_tuser    // [1:0] status
);

    logic [31:0] file_len_reg;
    logic        item_valid;
    in_item_t    item;
    logic        advance;
    logic        res_valid;
    result_t     res;
    result_t     res_out;

    // Hold the file length until rewritten.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_len_reg <= 32'd0;
        end else if (cfg_we) begin
            file_len_reg <= cfg_wdata;
        end
    end

    // Advance the parser whenever a byte waits and the result register can take a result.
    assign advance = item_valid && (!m_tvalid || m_tready);

    whp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    whp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (item),
        .total_len (file_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    whp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res_in   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_out)
    );

    // Pack the result, first field in the lowest bits.
    assign m_tdata = {res_out.pcm_length, res_out.pcm_start, res_out.sample_bits,
                      res_out.block_alignment, res_out.avg_byte_rate, res_out.sample_rate,
                      res_out.num_channels, res_out.audio_format};
    assign m_tuser = res_out.status;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !advance)
        else $error("parser advanced while a result was stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_OVERRUN)
        else $error("result carries an undefined status code");

endmodule
